### src/counted_id_table_unit_assert.svh
// Assertion macros shared by the counted id table RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef COUNTED_ID_TABLE_UNIT_ASSERT_SVH
`define COUNTED_ID_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("counted id table check failed");

// Next-cycle implication, disabled during reset.
`define CIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("counted id table check failed");

`endif

### src/cit_pkg.sv
// Package for the counted id table: field widths, command and status codes,
// engine states and the request and result structs. No dependencies.
`default_nettype none

package cit_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int IDENT_W         = 32;
    localparam int USAGE_W         = 16;

    typedef enum logic [1:0] {
        CMD_QUERY = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_INC   = 2'd2,
        CMD_DEC   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        t_cmd                 cmd;
        logic [IDENT_W-1:0]   ident;
    } t_req;

    typedef struct packed {
        logic                 found;
        logic [USAGE_W-1:0]   usage_count;
        t_status              status;
    } t_res;

endpackage

`default_nettype wire

### src/cit_ifs.sv
// Valid/ready channel interfaces for the counted id table.
// Depends on cit_pkg for the field widths.
`default_nettype none

interface cit_in_if import cit_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [IDENT_W-1:0] ident;

    modport source (output valid, output cmd, output ident, input ready);
    modport sink   (input valid, input cmd, input ident, output ready);
endinterface

interface cit_out_if import cit_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [USAGE_W-1:0] usage_count;
    logic [1:0]         status;

    modport source (output valid, output found, output usage_count, output status,
                    input ready);
    modport sink   (input valid, input found, input usage_count, input status,
                    output ready);
endinterface

`default_nettype wire

### src/counted_id_table_unit.sv
// Top level of the counted id table: channel handshakes and the result
// output register. Depends on cit_pkg, cit_ifs and cit_engine.
`default_nettype none

// Counted id table. Each accepted word (command and 32-bit id) is looked up by
// scanning the stored entries in order through the id memory's single read
// port, one entry per cycle, stopping at the first (lowest) match. A miss scans
// every stored entry; a hit ends the scan early. The input is ready only while
// the scan engine is idle. The engine is idle again once its result moves into
// the output register, so the next word can be accepted while that result
// waits. Add appends without a duplicate check and reports full when the table
// has no room; counts saturate at zero and at their maximum. After reset the
// table is empty and usable at once.
module counted_id_table_unit import cit_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cit_in_if.sink    i_in,
    cit_out_if.source o_out
);

    logic  w_idle;
    logic  w_start;
    logic  w_res_vld;
    logic  w_res_take;
    t_req  w_req;
    t_res  w_res;
    logic  r_out_vld;
    t_res  r_out;

    assign i_in.ready = w_idle;
    assign w_start    = i_in.valid && w_idle;
    assign w_req.cmd  = t_cmd'(i_in.cmd);
    assign w_req.ident = i_in.ident;

    cit_engine #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_BITS(COUNT_BITS)) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_req      (w_req),
        .o_idle     (w_idle),
        .o_res_vld  (w_res_vld),
        .o_res      (w_res),
        .i_res_take (w_res_take)
    );

    // The engine hands over its result once the output register is free or
    // is being emptied in the same cycle.
    assign w_res_take = w_res_vld && (!r_out_vld || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_take) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.found       = r_out.found;
    assign o_out.usage_count = r_out.usage_count;
    assign o_out.status      = r_out.status;

endmodule

`default_nettype wire

### src/cit_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/cit_engine.sv
// Scan engine of the counted id table: sequencer, id and count memories,
// the shared compare and the saturating count update.
// Depends on cit_pkg, cit_ram and the assertion macro header.
`default_nettype none
`include "counted_id_table_unit_assert.svh"

module cit_engine import cit_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    output logic      o_idle,
    output logic      o_res_vld,
    output t_res      o_res,
    input  wire logic i_res_take
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [FILL_W-1:0]     FILL_FULL = FILL_W'(TABLE_DEPTH);
    localparam logic [FILL_W-1:0]     IDX_ONE   = FILL_W'(1);
    localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [FILL_W-1:0]   r_rd_idx, n_rd_idx;
    logic                r_pend, n_pend;
    logic [ADDR_W-1:0]   r_cmp_idx, n_cmp_idx;
    t_cmd                r_cmd, n_cmd;
    logic [IDENT_W-1:0]  r_ident, n_ident;
    logic                r_found, n_found;
    logic [ADDR_W-1:0]   r_hit_idx, n_hit_idx;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    t_res                r_res, n_res;

    logic                  w_rd_en;
    logic                  w_match;
    logic                  w_full;
    logic [IDENT_W-1:0]    w_id_rdata;
    logic [COUNT_BITS-1:0] w_cnt_rdata;
    logic                  w_id_we;
    logic                  w_cnt_we;
    logic [ADDR_W-1:0]     w_cnt_waddr;
    logic [COUNT_BITS-1:0] w_cnt_wdata;
    logic [COUNT_BITS-1:0] w_cnt_out;
    logic [USAGE_W-1:0]    w_cnt_usage;
    t_status               w_status;

    cit_ram #(.WIDTH(IDENT_W), .DEPTH(TABLE_DEPTH)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (w_id_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (r_ident),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rdata (w_id_rdata)
    );

    cit_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rdata (w_cnt_rdata)
    );

    assign w_full  = (r_fill == FILL_FULL);
    assign w_match = r_pend && (w_id_rdata == r_ident);
    // One entry is read per cycle; the compare works on the registered read data
    // in the cycle after the read, so a hit stops further reads at once.
    assign w_rd_en = (r_state == ST_SCAN) && (r_rd_idx < r_fill) && !w_match;

    // Result and table update for the command once the scan has settled.
    always_comb begin
        w_id_we     = 1'b0;
        w_cnt_we    = 1'b0;
        w_cnt_waddr = r_hit_idx;
        w_cnt_wdata = r_cnt;
        w_cnt_out   = '0;
        w_status    = STAT_OK;
        case (r_cmd)
            CMD_ADD: begin
                if (!w_full) begin
                    w_id_we     = (r_state == ST_UPD);
                    w_cnt_we    = (r_state == ST_UPD);
                    w_cnt_waddr = r_fill[ADDR_W-1:0];
                    w_cnt_wdata = CNT_ONE;
                    w_cnt_out   = r_found ? r_cnt : CNT_ONE;
                end else begin
                    w_status  = STAT_FULL;
                    w_cnt_out = r_found ? r_cnt : '0;
                end
            end
            CMD_INC: begin
                if (r_found) begin
                    w_cnt_we    = (r_state == ST_UPD);
                    w_cnt_wdata = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_ONE;
                    w_cnt_out   = w_cnt_wdata;
                end else begin
                    w_status = STAT_NOT_FOUND;
                end
            end
            CMD_DEC: begin
                if (r_found) begin
                    w_cnt_we    = (r_state == ST_UPD);
                    w_cnt_wdata = (r_cnt == '0) ? r_cnt : r_cnt - CNT_ONE;
                    w_cnt_out   = w_cnt_wdata;
                end else begin
                    w_status = STAT_NOT_FOUND;
                end
            end
            default: begin
                if (r_found) begin
                    w_cnt_out = r_cnt;
                end else begin
                    w_status = STAT_NOT_FOUND;
                end
            end
        endcase
    end

    generate
        if (COUNT_BITS >= USAGE_W) begin : g_cnt_trunc
            assign w_cnt_usage = w_cnt_out[USAGE_W-1:0];
        end else begin : g_cnt_ext
            assign w_cnt_usage = {{(USAGE_W - COUNT_BITS){1'b0}}, w_cnt_out};
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_rd_idx  = r_rd_idx;
        n_pend    = w_rd_en;
        n_cmp_idx = r_rd_idx[ADDR_W-1:0];
        n_cmd     = r_cmd;
        n_ident   = r_ident;
        n_found   = r_found;
        n_hit_idx = r_hit_idx;
        n_cnt     = r_cnt;
        n_res     = r_res;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cmd    = i_req.cmd;
                    n_ident  = i_req.ident;
                    n_found  = 1'b0;
                    n_cnt    = '0;
                    n_rd_idx = '0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_rd_en) begin
                    n_rd_idx = r_rd_idx + IDX_ONE;
                end
                if (w_match) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_cmp_idx;
                    n_cnt     = w_cnt_rdata;
                    n_state   = ST_UPD;
                end else if (!r_pend && !w_rd_en) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (r_cmd == CMD_ADD && !w_full) begin
                    n_fill = r_fill + IDX_ONE;
                end
                n_res.found       = r_found;
                n_res.usage_count = w_cnt_usage;
                n_res.status      = w_status;
                n_state           = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
        end
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_cmd     <= n_cmd;
        r_ident   <= n_ident;
        r_found   <= n_found;
        r_hit_idx <= n_hit_idx;
        r_cnt     <= n_cnt;
        r_res     <= n_res;
    end

    assign o_idle    = (r_state == ST_IDLE);
    assign o_res_vld = (r_state == ST_DONE);
    assign o_res     = r_res;

    `CIT_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_FULL)
    `CIT_ASSERT_NOW(a_cmp_in_table, i_clk, i_rst_n, r_pend, FILL_W'(r_cmp_idx) < r_fill)
    `CIT_ASSERT_NOW(a_hit_in_table, i_clk, i_rst_n, (r_state == ST_UPD) && r_found,
                    FILL_W'(r_hit_idx) < r_fill)
    `CIT_ASSERT_NEXT(a_fill_only_on_add, i_clk, i_rst_n,
                     !((r_state == ST_UPD) && (r_cmd == CMD_ADD) && !w_full),
                     $stable(r_fill))

endmodule

`default_nettype wire

### test/tb_counted_id_table_unit.sv
`timescale 1ns / 1ps
// Testbench for counted_id_table_unit: directed words, a back-to-back burst
// and random traffic, scored against an in-bench table predictor or typed-in results.
// Depends on cit_pkg, cit_ifs and the counted_id_table_unit RTL.

module tb_counted_id_table_unit;
    import cit_pkg::*;

    localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
    localparam int COUNT_BITS   = COUNT_BITS_DEF;
    localparam int RANDOM_WORDS = 2000;
    localparam int BURST_WORDS  = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 100;

    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam t_res NO_RES = '{found: 1'b0, usage_count: '0, status: STAT_OK};

    typedef struct {
        t_cmd               cmd;
        logic [IDENT_W-1:0] ident;
        bit                 typed;
        t_res               want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    cit_in_if  in_ch ();
    cit_out_if out_ch ();

    counted_id_table_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Predictor state: a mirror of the id table.
    logic [IDENT_W-1:0]    table_ids    [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] table_counts [TABLE_DEPTH];
    int                    table_fill;

    t_res pending_results [$];
    int   mismatches;
    int   hold_cycles;
    bit   src_quiet;
    bit   sink_quiet;
    bit   fast_phase;

    // The expected result is typed in only where it is plain from the
    // command history; the other rows rely on the predictor.
    t_dir_row directed_rows [22] = '{
        '{CMD_QUERY, 32'h0000_0000, 1'b1, '{1'b0, 16'd0, STAT_NOT_FOUND}},
        '{CMD_INC,   32'hFFFF_FFFF, 1'b1, '{1'b0, 16'd0, STAT_NOT_FOUND}},
        '{CMD_DEC,   32'h0000_0000, 1'b1, '{1'b0, 16'd0, STAT_NOT_FOUND}},
        '{CMD_ADD,   32'h0000_0000, 1'b1, '{1'b0, 16'd1, STAT_OK}},
        '{CMD_ADD,   32'hFFFF_FFFF, 1'b1, '{1'b0, 16'd1, STAT_OK}},
        '{CMD_ADD,   32'h0000_0000, 1'b1, '{1'b1, 16'd1, STAT_OK}},
        '{CMD_INC,   32'h0000_0000, 1'b1, '{1'b1, 16'd2, STAT_OK}},
        '{CMD_QUERY, 32'h0000_0000, 1'b1, '{1'b1, 16'd2, STAT_OK}},
        '{CMD_DEC,   32'h0000_0000, 1'b1, '{1'b1, 16'd1, STAT_OK}},
        '{CMD_DEC,   32'h0000_0000, 1'b1, '{1'b1, 16'd0, STAT_OK}},
        '{CMD_DEC,   32'h0000_0000, 1'b1, '{1'b1, 16'd0, STAT_OK}},
        '{CMD_QUERY, 32'hFFFF_FFFF, 1'b1, '{1'b1, 16'd1, STAT_OK}},
        '{CMD_ADD,   32'h8000_0000, 1'b0, NO_RES},
        '{CMD_ADD,   32'h0000_0001, 1'b0, NO_RES},
        '{CMD_INC,   32'h8000_0000, 1'b0, NO_RES},
        '{CMD_QUERY, 32'hAAAA_AAAA, 1'b1, '{1'b0, 16'd0, STAT_NOT_FOUND}},
        '{CMD_ADD,   32'hAAAA_AAAA, 1'b0, NO_RES},
        '{CMD_ADD,   32'h5555_5555, 1'b0, NO_RES},
        '{CMD_DEC,   32'h5555_5555, 1'b0, NO_RES},
        '{CMD_QUERY, 32'h5555_5555, 1'b0, NO_RES},
        '{CMD_INC,   32'h0000_0001, 1'b0, NO_RES},
        '{CMD_QUERY, 32'h0000_0001, 1'b0, NO_RES}
    };

    always #5 i_clk = ~i_clk;

    // Applies one command to the mirrored table and returns its result.
    function automatic t_res apply_command(input t_cmd c, input logic [IDENT_W-1:0] id);
        int   hit;
        t_res res;
        hit = -1;
        for (int i = 0; i < table_fill; i++) begin
            if (hit < 0 && table_ids[i] == id) begin
                hit = i;
            end
        end
        res = '{found: (hit >= 0), usage_count: '0, status: STAT_OK};
        case (c)
            CMD_ADD: begin
                if (table_fill < TABLE_DEPTH) begin
                    table_ids[table_fill]    = id;
                    table_counts[table_fill] = COUNT_ONE;
                    if (hit < 0) begin
                        hit = table_fill;
                    end
                    table_fill++;
                end else begin
                    res.status = STAT_FULL;
                end
                if (hit >= 0) begin
                    res.usage_count = USAGE_W'(table_counts[hit]);
                end
            end
            CMD_INC, CMD_DEC: begin
                if (hit >= 0) begin
                    if (c == CMD_INC && table_counts[hit] != COUNT_TOP) begin
                        table_counts[hit] = table_counts[hit] + 1'b1;
                    end else if (c == CMD_DEC && table_counts[hit] != '0) begin
                        table_counts[hit] = table_counts[hit] - 1'b1;
                    end
                    res.usage_count = USAGE_W'(table_counts[hit]);
                end else begin
                    res.status = STAT_NOT_FOUND;
                end
            end
            default: begin
                if (hit >= 0) begin
                    res.usage_count = USAGE_W'(table_counts[hit]);
                end else begin
                    res.status = STAT_NOT_FOUND;
                end
            end
        endcase
        return res;
    endfunction

    function automatic int draw_wait(input bit quiet);
        return (quiet || fast_phase) ? 0 : $urandom_range(0, 8);
    endfunction

    // Mostly ids already stored, so that hits and duplicates are common.
    function automatic logic [IDENT_W-1:0] pick_ident();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5 && table_fill > 0) begin
            return table_ids[$urandom_range(0, table_fill - 1)];
        end else if (sel == 6) begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return '1;
                default: return 32'h1 << $urandom_range(0, 31);
            endcase
        end
        return $urandom;
    endfunction

    // Offers one word and records its expected result at acceptance.
    // Called and returns at a falling edge; valid stays high on return.
    task automatic send_word(input t_cmd c, input logic [IDENT_W-1:0] id,
                             input bit typed, input t_res want);
        int   gap;
        t_res pred;
        gap = draw_wait(src_quiet);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.cmd   = c;
        in_ch.ident = id;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        pred = apply_command(c, id);
        pending_results.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    initial begin : result_sink
        int   gap;
        int   seen;
        t_res want;
        seen = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                out_ch.ready = 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            gap = draw_wait(sink_quiet);
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            @(posedge i_clk);
            while (out_ch.valid !== 1'b1) @(posedge i_clk);
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, out_ch.found);
                    mismatches++;
                end
                if (out_ch.usage_count !== want.usage_count) begin
                    $error("usage_count: expected %0d, actual %0d",
                           want.usage_count, out_ch.usage_count);
                    mismatches++;
                end
                if (out_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, out_ch.status);
                    mismatches++;
                end
            end
            seen++;
            if (seen % 50 == 0) begin
                sink_quiet = ($urandom_range(0, 3) == 0);
            end
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int                 pick;
        t_cmd               c;
        logic [IDENT_W-1:0] id;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.cmd    = CMD_QUERY;
        in_ch.ident  = '0;
        out_ch.ready = 1'b0;
        table_fill   = 0;
        mismatches   = 0;
        hold_cycles  = 0;
        src_quiet    = 1'b0;
        sink_quiet   = 1'b0;
        fast_phase   = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].cmd, directed_rows[i].ident,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        // Id 0 sits at entry 0 with count 0: a gapless burst of increments
        // on it, then one step back down.
        fast_phase = 1'b1;
        repeat (BURST_WORDS) send_word(CMD_INC, 32'h0, 1'b0, NO_RES);
        send_word(CMD_DEC, 32'h0, 1'b0, NO_RES);
        fast_phase = 1'b0;

        // Adds are rare enough that the table fills about halfway through,
        // leaving plenty of traffic against a full table.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0) begin
                src_quiet = ($urandom_range(0, 3) == 0);
            end
            if (n == 600) begin
                hold_cycles = HOLD_CYCLES;
            end
            if (n == 1300) begin
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                c = CMD_ADD;
            end else if (pick < 35) begin
                c = CMD_QUERY;
            end else if (pick < 70) begin
                c = CMD_INC;
            end else begin
                c = CMD_DEC;
            end
            id = pick_ident();
            send_word(c, id, 1'b0, NO_RES);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #100ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/cit_pkg.sv
src/cit_ifs.sv
src/cit_ram.sv
src/cit_engine.sv
src/counted_id_table_unit.sv
test/tb_counted_id_table_unit.sv
